/* design/lhd_pkg.sv */
// Shared types, sizes and codes for the linear-hash dedup set.
// Used by the controller, the top level and the port checker.
package lhd_pkg;

	localparam int SLOTS_PER_PAGE = 256;
	localparam int MAX_PAGES      = 64;
	localparam int MAX_BUCKETS    = 32;

	localparam int SLOT_W  = $clog2(SLOTS_PER_PAGE);
	localparam int PAGE_W  = $clog2(MAX_PAGES);
	localparam int LINK_W  = PAGE_W + 1;
	localparam int BKT_W   = $clog2(MAX_BUCKETS);
	localparam int BCNT_W  = BKT_W + 1;
	localparam int MOD_W   = BKT_W + 2;
	localparam int ADDR_W  = PAGE_W + SLOT_W;
	localparam int DEPTH   = MAX_PAGES * SLOTS_PER_PAGE;
	localparam int KCNT_W  = 15;
	localparam int FILL_W  = SLOT_W + 1;
	localparam int CMP_W   = 22;

	localparam logic [31:0]       EMPTY_KEY = 32'h8000_0000;
	localparam logic [LINK_W-1:0] NO_PAGE   = LINK_W'(MAX_PAGES);
	localparam logic [6:0]        LOAD_RESET = 7'd75;

	typedef enum logic [1:0] {
		STAT_NEW  = 2'd0,
		STAT_DUP  = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_SCAN, S_INS_WR, S_CHECK,
		S_SPLIT_INIT, S_CNT_END, S_MOVE_WR, S_RESULT
	} state_t;

	typedef enum logic [1:0] {
		M_INS, M_CNT, M_MOV
	} mode_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [31:0]       wdata;
	} slot_req_t;

	typedef struct packed {
		logic              we;
		logic [PAGE_W-1:0] addr;
		logic [LINK_W-1:0] wdata;
	} link_req_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] key;
		status_t     status;
	} result_t;

	// largest power of two not above sz (sz >= 1)
	function automatic logic [BCNT_W-1:0] half_of(input logic [BCNT_W-1:0] sz);
		logic [BCNT_W-1:0] h;
		h = BCNT_W'(1);
		for (int i = 1; i < BCNT_W; i++) begin
			if (sz >= BCNT_W'(1 << i)) h = BCNT_W'(1 << i);
		end
		return h;
	endfunction

endpackage

/* design/lhd_ram.sv */
// Generic single-port synchronous RAM with a registered read.
// Read data holds its value during a write cycle. No dependencies.
module lhd_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write or registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata <= mem[addr];
		end
	end

endmodule

/* design/lhd_ctrl.sv */
// Sequencer of the dedup set: chain scans, inserts, splits and the clearing pass.
// Depends on lhd_pkg; drives the slot and link RAM ports held by the top level.
module lhd_ctrl
	import lhd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [31:0]       in_key,
	input  logic [6:0]        load_limit,
	output result_t           res,
	input  logic              res_ready,
	output slot_req_t         slot_req,
	input  logic [31:0]       slot_rdata,
	output link_req_t         link_req,
	input  logic [LINK_W-1:0] link_rdata
);

	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS_PER_PAGE - 1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(SLOTS_PER_PAGE);

	state_t state_q, state_n;
	mode_t  mode_q;

	logic [31:0]         key_q;
	status_t             status_q;
	logic [PAGE_W-1:0]   iss_page_q;
	logic [SLOT_W-1:0]   iss_slot_q;
	logic                iss_done_q;
	logic                v_s1, last_s1;
	logic [PAGE_W-1:0]   page_s1;
	logic [SLOT_W-1:0]   slot_s1;
	logic                fe_found_q;
	logic [PAGE_W-1:0]   fe_page_q;
	logic [SLOT_W-1:0]   fe_slot_q;
	logic [LINK_W-1:0]   pages_used_q;
	logic [BCNT_W-1:0]   bucket_total_q;
	logic [MOD_W-1:0]    hash_mod_q;
	logic [KCNT_W-1:0]   key_total_q;
	logic [PAGE_W-1:0]   head_q [MAX_BUCKETS];
	logic [BKT_W-1:0]    old_q;
	logic [BCNT_W-1:0]   mask_q;
	logic [MOD_W-1:0]    mod_new_q;
	logic [KCNT_W-1:0]   moving_q;
	logic [PAGE_W-1:0]   fill_page_q;
	logic [FILL_W-1:0]   fill_cnt_q;
	logic [31:0]         mv_key_q;
	logic                mv_last_q;
	logic [ADDR_W-1:0]   clr_q;

	logic                hit, movable, iss_last, issue;
	logic [BCNT_W-1:0]   idx_raw, idx_adj, idx_mask;
	logic [BKT_W-1:0]    bidx;
	logic [BCNT_W-1:0]   half, sz_plus;
	logic [BKT_W-1:0]    old_n;
	logic [MOD_W-1:0]    mod_n;
	logic [LINK_W:0]     need, pages_sum;
	logic                split_fits;
	logic [CMP_W-1:0]    lhs, rhs;
	logic                over_load;

	// compare and address decode
	always_comb begin
		hit      = v_s1 && (slot_rdata == key_q);
		movable  = v_s1 && (slot_rdata != EMPTY_KEY)
			&& ((slot_rdata[BCNT_W-1:0] & mask_q) != {1'b0, old_q});
		iss_last = (iss_slot_q == SLOT_LAST) && (link_rdata >= NO_PAGE);
		issue    = (state_q == S_SCAN) && !iss_done_q
			&& !((mode_q == M_INS) && hit) && !((mode_q == M_MOV) && movable);

		// bucket of the incoming key
		idx_mask = hash_mod_q[BCNT_W-1:0] - BCNT_W'(1);
		idx_raw  = in_key[BCNT_W-1:0] & idx_mask;
		idx_adj  = (idx_raw >= bucket_total_q) ? idx_raw - hash_mod_q[BCNT_W:1] : idx_raw;
		bidx     = (idx_adj >= BCNT_W'(MAX_BUCKETS)) ? '0 : idx_adj[BKT_W-1:0];

		// split order
		half    = half_of(bucket_total_q);
		sz_plus = bucket_total_q + BCNT_W'(1);
		old_n   = BKT_W'(bucket_total_q - half);
		mod_n   = ({1'b0, sz_plus} > hash_mod_q) ? {hash_mod_q[MOD_W-2:0], 1'b0} : hash_mod_q;

		// pages the new bucket needs
		need       = (LINK_W+1)'((moving_q + KCNT_W'(SLOTS_PER_PAGE - 1)) >> SLOT_W);
		if (need == '0) need = (LINK_W+1)'(1);
		pages_sum  = {1'b0, pages_used_q} + need;
		split_fits = pages_sum <= (LINK_W+1)'(MAX_PAGES);

		// load check
		lhs       = CMP_W'(key_total_q) * CMP_W'(100);
		rhs       = (CMP_W'(load_limit) * CMP_W'(pages_used_q)) << SLOT_W;
		over_load = lhs > rhs;
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			S_CLEAR: if (clr_q == ADDR_W'(DEPTH - 1)) state_n = S_IDLE;
			S_IDLE: begin
				if (in_valid) state_n = (in_key == EMPTY_KEY) ? S_RESULT : S_SCAN;
			end
			S_SCAN: begin
				case (mode_q)
					M_INS: begin
						if (hit) state_n = S_RESULT;
						else if (v_s1 && last_s1) state_n = S_INS_WR;
					end
					M_CNT: if (v_s1 && last_s1) state_n = S_CNT_END;
					M_MOV: begin
						if (movable) state_n = S_MOVE_WR;
						else if (v_s1 && last_s1) state_n = S_RESULT;
					end
					default: state_n = S_RESULT;
				endcase
			end
			S_INS_WR: begin
				state_n = (!fe_found_q && pages_used_q >= NO_PAGE) ? S_RESULT : S_CHECK;
			end
			S_CHECK: begin
				state_n = (over_load && bucket_total_q < BCNT_W'(MAX_BUCKETS))
					? S_SPLIT_INIT : S_RESULT;
			end
			S_SPLIT_INIT: state_n = S_SCAN;
			S_CNT_END:    state_n = split_fits ? S_SCAN : S_RESULT;
			S_MOVE_WR:    state_n = mv_last_q ? S_RESULT : S_SCAN;
			S_RESULT:     if (res_ready) state_n = S_IDLE;
			default:      state_n = S_IDLE;
		endcase
	end

	// RAM ports and handshake outputs
	always_comb begin
		slot_req.we    = 1'b0;
		slot_req.addr  = {iss_page_q, iss_slot_q};
		slot_req.wdata = key_q;
		link_req.we    = 1'b0;
		link_req.addr  = iss_page_q;
		link_req.wdata = pages_used_q;
		case (state_q)
			S_CLEAR: begin
				slot_req.we    = 1'b1;
				slot_req.addr  = clr_q;
				slot_req.wdata = EMPTY_KEY;
				link_req.we    = clr_q < ADDR_W'(MAX_PAGES);
				link_req.addr  = clr_q[PAGE_W-1:0];
				link_req.wdata = NO_PAGE;
			end
			S_SCAN: begin
				if ((mode_q == M_MOV) && movable) begin
					slot_req.we    = 1'b1;
					slot_req.addr  = {page_s1, slot_s1};
					slot_req.wdata = EMPTY_KEY;
				end
			end
			S_INS_WR: begin
				if (fe_found_q) begin
					slot_req.we   = 1'b1;
					slot_req.addr = {fe_page_q, fe_slot_q};
				end else if (pages_used_q < NO_PAGE) begin
					slot_req.we   = 1'b1;
					slot_req.addr = {pages_used_q[PAGE_W-1:0], SLOT_W'(0)};
					link_req.we   = 1'b1;
					link_req.addr = page_s1;
				end
			end
			S_MOVE_WR: begin
				slot_req.we    = 1'b1;
				slot_req.wdata = mv_key_q;
				if (fill_cnt_q == FILL_FULL) begin
					slot_req.addr = {pages_used_q[PAGE_W-1:0], SLOT_W'(0)};
					link_req.we   = 1'b1;
					link_req.addr = fill_page_q;
				end else begin
					slot_req.addr = {fill_page_q, fill_cnt_q[SLOT_W-1:0]};
				end
			end
			default: ;
		endcase
		in_ready   = (state_q == S_IDLE);
		res.valid  = (state_q == S_RESULT);
		res.key    = key_q;
		res.status = status_q;
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			mode_q         <= M_INS;
			key_q          <= '0;
			status_q       <= STAT_NEW;
			iss_page_q     <= '0;
			iss_slot_q     <= '0;
			iss_done_q     <= 1'b0;
			v_s1           <= 1'b0;
			last_s1        <= 1'b0;
			page_s1        <= '0;
			slot_s1        <= '0;
			fe_found_q     <= 1'b0;
			fe_page_q      <= '0;
			fe_slot_q      <= '0;
			pages_used_q   <= LINK_W'(2);
			bucket_total_q <= BCNT_W'(2);
			hash_mod_q     <= MOD_W'(2);
			key_total_q    <= '0;
			for (int i = 0; i < MAX_BUCKETS; i++) head_q[i] <= (i == 1) ? PAGE_W'(1) : '0;
			old_q          <= '0;
			mask_q         <= '0;
			mod_new_q      <= '0;
			moving_q       <= '0;
			fill_page_q    <= '0;
			fill_cnt_q     <= '0;
			mv_key_q       <= '0;
			mv_last_q      <= 1'b0;
			clr_q          <= '0;
		end else begin
			state_q <= state_n;
			v_s1    <= 1'b0;
			case (state_q)
				S_CLEAR: clr_q <= clr_q + ADDR_W'(1);
				S_IDLE: begin
					if (in_valid) begin
						key_q      <= in_key;
						status_q   <= (in_key == EMPTY_KEY) ? STAT_DUP : STAT_NEW;
						iss_page_q <= head_q[bidx];
						iss_slot_q <= '0;
						iss_done_q <= 1'b0;
						fe_found_q <= 1'b0;
						mode_q     <= M_INS;
					end
				end
				S_SCAN: begin
					// issue the next slot read
					if (issue) begin
						v_s1    <= 1'b1;
						page_s1 <= iss_page_q;
						slot_s1 <= iss_slot_q;
						last_s1 <= iss_last;
						if (iss_slot_q == SLOT_LAST) begin
							if (iss_last) iss_done_q <= 1'b1;
							else begin
								iss_page_q <= link_rdata[PAGE_W-1:0];
								iss_slot_q <= '0;
							end
						end else begin
							iss_slot_q <= iss_slot_q + SLOT_W'(1);
						end
					end
					// act on the slot read last cycle
					case (mode_q)
						M_INS: begin
							if (hit) status_q <= STAT_DUP;
							else if (v_s1 && slot_rdata == EMPTY_KEY && !fe_found_q) begin
								fe_found_q <= 1'b1;
								fe_page_q  <= page_s1;
								fe_slot_q  <= slot_s1;
							end
						end
						M_CNT: if (movable) moving_q <= moving_q + KCNT_W'(1);
						M_MOV: begin
							if (movable) begin
								mv_key_q  <= slot_rdata;
								mv_last_q <= last_s1;
							end
						end
						default: ;
					endcase
				end
				S_INS_WR: begin
					if (fe_found_q) begin
						key_total_q <= key_total_q + KCNT_W'(1);
					end else if (pages_used_q >= NO_PAGE) begin
						status_q <= STAT_FULL;
					end else begin
						pages_used_q <= pages_used_q + LINK_W'(1);
						key_total_q  <= key_total_q + KCNT_W'(1);
					end
				end
				S_SPLIT_INIT: begin
					old_q      <= old_n;
					mod_new_q  <= mod_n;
					mask_q     <= mod_n[BCNT_W-1:0] - BCNT_W'(1);
					iss_page_q <= head_q[old_n];
					iss_slot_q <= '0;
					iss_done_q <= 1'b0;
					moving_q   <= '0;
					mode_q     <= M_CNT;
				end
				S_CNT_END: begin
					if (split_fits) begin
						head_q[bucket_total_q[BKT_W-1:0]] <= pages_used_q[PAGE_W-1:0];
						fill_page_q    <= pages_used_q[PAGE_W-1:0];
						fill_cnt_q     <= '0;
						pages_used_q   <= pages_used_q + LINK_W'(1);
						bucket_total_q <= bucket_total_q + BCNT_W'(1);
						hash_mod_q     <= mod_new_q;
						iss_page_q     <= head_q[old_q];
						iss_slot_q     <= '0;
						iss_done_q     <= 1'b0;
						mode_q         <= M_MOV;
					end
				end
				S_MOVE_WR: begin
					if (fill_cnt_q == FILL_FULL) begin
						fill_page_q  <= pages_used_q[PAGE_W-1:0];
						fill_cnt_q   <= FILL_W'(1);
						pages_used_q <= pages_used_q + LINK_W'(1);
					end else begin
						fill_cnt_q <= fill_cnt_q + FILL_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

endmodule

/* design/linear_hash_dedup_set.sv */
// Top level of the linear-hash dedup set: config register, output register, RAMs.
// Depends on lhd_pkg, lhd_ram and lhd_ctrl.
//
//  channel   direction  signals                               transfer carries
//  s_axis    in         s_axis_tvalid/tready/tdata[31:0]      key_in
//  m_axis    out        m_axis_tvalid/tready/tdata[39:0]      key_out, status
//  cfg       in         cfg_valid/cfg_ready/cfg_data[6:0]     load_limit_percent
//
// An insert scans the key's bucket chain one slot per cycle, page by page;
// a duplicate stops at the matching slot. A split adds two scans of the split
// bucket's chain, the second pausing to write each moved key; the slot RAM's
// single port sets this rate. After reset a clearing pass over all 16384 slots
// empties the slot RAM, with s_axis_tready low. The output register
// lets a new key be taken while a result waits on m_axis_tready.
module linear_hash_dedup_set
	import lhd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] key_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [31:0] key_out, [33:32] status, rest zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data
);

	logic [6:0]        load_limit_q;
	result_t           res;
	logic              res_ready;
	slot_req_t         slot_req;
	link_req_t         link_req;
	logic [31:0]       slot_rdata;
	logic [LINK_W-1:0] link_rdata;
	logic              out_valid_q;
	logic [31:0]       out_key_q;
	status_t           out_status_q;

	// load limit register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_limit_q <= LOAD_RESET;
		end else if (cfg_valid) begin
			load_limit_q <= cfg_data;
		end
	end

	// output register
	assign res_ready = !out_valid_q || m_axis_tready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			out_key_q    <= res.key;
			out_status_q <= res.status;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_status_q, out_key_q};

	lhd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_key     (s_axis_tdata),
		.load_limit (load_limit_q),
		.res        (res),
		.res_ready  (res_ready),
		.slot_req   (slot_req),
		.slot_rdata (slot_rdata),
		.link_req   (link_req),
		.link_rdata (link_rdata)
	);

	// key slots of all pages
	lhd_ram #(.DEPTH(DEPTH), .WIDTH(32)) u_slot_ram (
		.clk   (clk),
		.we    (slot_req.we),
		.addr  (slot_req.addr),
		.wdata (slot_req.wdata),
		.rdata (slot_rdata)
	);

	// next-page links
	lhd_ram #(.DEPTH(MAX_PAGES), .WIDTH(LINK_W)) u_link_ram (
		.clk   (clk),
		.we    (link_req.we),
		.addr  (link_req.addr),
		.wdata (link_req.wdata),
		.rdata (link_rdata)
	);

endmodule

/* design/lhd_checker.sv */
// Port-level checks for linear_hash_dedup_set, attached by bind.
// Depends on lhd_pkg for status codes and the empty marker.
module lhd_port_sva
	import lhd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [31:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [6:0]  cfg_data
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// only defined status codes
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[33:32] == STAT_NEW || m_axis_tdata[33:32] == STAT_DUP
			|| m_axis_tdata[33:32] == STAT_FULL))
		else $error("bad status code");

	// the empty marker is always reported as a duplicate
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[31:0] == EMPTY_KEY |-> m_axis_tdata[33:32] == STAT_DUP)
		else $error("empty marker not reported as duplicate");

	// one key in work at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second key taken while busy");

endmodule

bind linear_hash_dedup_set lhd_port_sva u_lhd_port_sva (.*);

/* dv/lhd_checker.sv */
// Port checker for the linear-hash dedup set: watches s_axis, m_axis and cfg transfers.
// Keeps its own copy of the hashed table and compares every result.
// Depends on lhd_pkg.
`timescale 1ns / 100ps

module lhd_checker
	import lhd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] key_in
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,   // [31:0] key_out, [33:32] status, rest zero
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [6:0]  cfg_data,
	output int          fail_count,
	output int          pending,
	output int          new_seen,
	output int          dup_seen,
	output int          full_seen
);

	typedef struct {
		logic [31:0] key;
		status_t     st;
	} verdict_t;

	verdict_t    verdict_q[$];
	logic [31:0] slot_mem [DEPTH];
	int unsigned next_link [MAX_PAGES];
	int unsigned chain_head [MAX_BUCKETS];
	int unsigned pages_taken, buckets, modulus, stored, load_pct;

	task automatic mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		fail_count++;
	endtask

	function automatic void table_reset();
		for (int i = 0; i < DEPTH; i++) slot_mem[i] = EMPTY_KEY;
		for (int i = 0; i < MAX_PAGES; i++) next_link[i] = MAX_PAGES;
		for (int i = 0; i < MAX_BUCKETS; i++) chain_head[i] = 0;
		chain_head[1] = 1;
		pages_taken = 2;
		buckets     = 2;
		modulus     = 2;
		stored      = 0;
		load_pct    = LOAD_RESET;
	endfunction

	function automatic bit chain_has(input int unsigned hd, input logic [31:0] k);
		int unsigned p, g;
		p = hd;
		g = 0;
		while (p < MAX_PAGES && g < MAX_PAGES) begin
			for (int i = 0; i < SLOTS_PER_PAGE; i++)
				if (slot_mem[p * SLOTS_PER_PAGE + i] == k) return 1'b1;
			p = next_link[p];
			g++;
		end
		return 1'b0;
	endfunction

	// first empty slot of the chain, or a fresh page at its tail
	function automatic bit chain_put(input int unsigned hd, input logic [31:0] k);
		int unsigned p, g;
		p = hd;
		g = 0;
		while (p < MAX_PAGES && g < MAX_PAGES) begin
			for (int i = 0; i < SLOTS_PER_PAGE; i++) begin
				if (slot_mem[p * SLOTS_PER_PAGE + i] == EMPTY_KEY) begin
					slot_mem[p * SLOTS_PER_PAGE + i] = k;
					return 1'b1;
				end
			end
			if (next_link[p] >= MAX_PAGES) begin
				if (pages_taken >= MAX_PAGES) return 1'b0;
				next_link[p] = pages_taken;
				next_link[pages_taken] = MAX_PAGES;
				slot_mem[pages_taken * SLOTS_PER_PAGE] = k;
				pages_taken++;
				return 1'b1;
			end
			p = next_link[p];
			g++;
		end
		return 1'b0;
	endfunction

	function automatic void split_bucket();
		int unsigned sz, half, victim, nmod, mask, moving, p, g, need, fresh;
		logic [31:0] k;
		sz = buckets;
		if (sz >= MAX_BUCKETS) return;
		half = 1;
		while (half * 2 <= sz) half *= 2;
		victim = sz - half;
		nmod   = (sz + 1 > modulus) ? modulus * 2 : modulus;
		mask   = nmod - 1;
		moving = 0;
		p = chain_head[victim];
		g = 0;
		while (p < MAX_PAGES && g < MAX_PAGES) begin
			for (int i = 0; i < SLOTS_PER_PAGE; i++) begin
				k = slot_mem[p * SLOTS_PER_PAGE + i];
				if (k != EMPTY_KEY && (k & mask) != victim) moving++;
			end
			p = next_link[p];
			g++;
		end
		need = (moving + SLOTS_PER_PAGE - 1) / SLOTS_PER_PAGE;
		if (need == 0) need = 1;
		if (pages_taken + need > MAX_PAGES) return;
		fresh = pages_taken;
		pages_taken++;
		next_link[fresh] = MAX_PAGES;
		chain_head[sz] = fresh;
		buckets = sz + 1;
		modulus = nmod;
		p = chain_head[victim];
		g = 0;
		while (p < MAX_PAGES && g < MAX_PAGES) begin
			for (int i = 0; i < SLOTS_PER_PAGE; i++) begin
				k = slot_mem[p * SLOTS_PER_PAGE + i];
				if (k != EMPTY_KEY && (k & mask) != victim) begin
					slot_mem[p * SLOTS_PER_PAGE + i] = EMPTY_KEY;
					void'(chain_put(fresh, k));
				end
			end
			p = next_link[p];
			g++;
		end
	endfunction

	function automatic status_t insert_key(input logic [31:0] k);
		int unsigned b;
		longint unsigned lhs, rhs;
		if (k == EMPTY_KEY) return STAT_DUP;
		b = k & (modulus - 1);
		if (b >= buckets) b -= modulus / 2;
		if (b >= MAX_BUCKETS) b = 0;
		if (chain_has(chain_head[b], k)) return STAT_DUP;
		if (!chain_put(chain_head[b], k)) return STAT_FULL;
		stored++;
		lhs = longint'(stored) * 100;
		rhs = longint'(load_pct) * SLOTS_PER_PAGE * pages_taken;
		if (lhs > rhs) split_bucket();
		return STAT_NEW;
	endfunction

	assign pending = verdict_q.size();

	// predict on key transfers, compare on result transfers
	always @(posedge clk or negedge arst_n) begin
		verdict_t v;
		if (!arst_n) begin
			table_reset();
			verdict_q.delete();
			fail_count = 0;
			new_seen   = 0;
			dup_seen   = 0;
			full_seen  = 0;
		end else begin
			if (cfg_valid && cfg_ready) load_pct = cfg_data;
			if (s_axis_tvalid && s_axis_tready) begin
				v.key = s_axis_tdata;
				v.st  = insert_key(s_axis_tdata);
				verdict_q.push_back(v);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (verdict_q.size() == 0) begin
					mismatch($sformatf("unexpected result key %h", m_axis_tdata[31:0]));
				end else begin
					v = verdict_q.pop_front();
					if (m_axis_tdata[31:0] != v.key)
						mismatch($sformatf("key_out %h, want %h", m_axis_tdata[31:0], v.key));
					if (m_axis_tdata[33:32] != v.st)
						mismatch($sformatf("status %0d for key %h, want %0d",
							m_axis_tdata[33:32], v.key, v.st));
					if (m_axis_tdata[39:34] != '0)
						mismatch($sformatf("pad bits %h for key %h", m_axis_tdata[39:34], v.key));
					case (v.st)
						STAT_NEW:  new_seen++;
						STAT_DUP:  dup_seen++;
						default:   full_seen++;
					endcase
				end
			end
		end
	end

endmodule

/* dv/linear_hash_dedup_set_tb.sv */
// Testbench top for the linear-hash dedup set: clock, reset, key and config stimulus.
// Depends on lhd_pkg, linear_hash_dedup_set and lhd_checker.
`timescale 1ns / 100ps

module linear_hash_dedup_set_tb;
	import lhd_pkg::*;

	localparam int IDLE_LIMIT = 400000;
	localparam int PHASE_KEYS = 200;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [6:0]  cfg_data;

	int fail_count, pending, new_seen, dup_seen, full_seen;
	int idle_cycles;
	int stall_mode;
	int keys_sent;
	int settings_done;
	logic [31:0] sent_keys[$];

	linear_hash_dedup_set dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	lhd_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending),
		.new_seen(new_seen), .dup_seen(dup_seen), .full_seen(full_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side stalls: mode 0 never, 1 light, 2 heavy, 3 long runs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			case (stall_mode)
				0:       m_axis_tready <= 1'b1;
				1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
				2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
				default: m_axis_tready <= ($urandom_range(0, 15) == 0) ? ~m_axis_tready
				                                                       : m_axis_tready;
			endcase
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
		    (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", idle_cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	// one key transfer; valid stays up if the next key follows directly
	task automatic push_key(input logic [31:0] k);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= k;
		forever begin
			@(negedge clk);
			if (s_axis_tready) break;
		end
		@(posedge clk);
		keys_sent++;
		if (sent_keys.size() < 400) sent_keys.push_back(k);
		else sent_keys[$urandom_range(0, 399)] = k;
	endtask

	task automatic drop_valid(input int gap);
		s_axis_tvalid <= 1'b0;
		repeat (gap) @(posedge clk);
	endtask

	task automatic write_load(input logic [6:0] pct);
		wait (pending == 0);
		repeat (20) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= pct;
		forever begin
			@(negedge clk);
			if (cfg_ready) break;
		end
		@(posedge clk);
		cfg_valid <= 1'b0;
		settings_done++;
	endtask

	function automatic logic [31:0] pick_key();
		logic [31:0] k;
		case ($urandom_range(0, 9))
			0, 1, 2: k = (sent_keys.size() != 0) ? sent_keys[$urandom_range(0, sent_keys.size() - 1)]
			                                     : $urandom;
			3, 4, 5: k = $urandom;
			6:       k = $urandom_range(0, 511) - 256;
			7:       k = $urandom << 5;
			8:       k = ($urandom_range(0, 3) == 0) ? EMPTY_KEY : ~$urandom_range(0, 63);
			default: k = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom_range(0, 2047))};
		endcase
		return k;
	endfunction

	// random keys in bursts, often with gaps between them
	task automatic random_keys(input int count);
		int left, burst;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 12);
			if (burst > left) burst = left;
			repeat (burst) push_key(pick_key());
			left -= burst;
			if ($urandom_range(0, 2) != 0) drop_valid($urandom_range(1, 8));
		end
		drop_valid(0);
	endtask

	logic [31:0] directed_keys [20] = '{
		32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, EMPTY_KEY,
		EMPTY_KEY, 32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h0000_0002,
		32'h0000_0003, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0001, 32'h0000_0020,
		32'h0000_0040, 32'hFFFF_FFE0, 32'h0000_0005, 32'h0000_0001, 32'hFFFF_FFFF
	};

	logic [6:0] load_plan [6] = '{7'd100, 7'd1, 7'd0, 7'd127, 7'd50, 7'd75};

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		stall_mode    = 0;
		idle_cycles   = 0;
		keys_sent     = 0;
		settings_done = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, the empty marker and repeats at the reset load setting
		foreach (directed_keys[i]) begin
			push_key(directed_keys[i]);
			if (i % 4 == 3) drop_valid($urandom_range(0, 3));
		end
		drop_valid(0);

		foreach (load_plan[i]) begin
			write_load(load_plan[i]);
			stall_mode = i % 4;
			random_keys(PHASE_KEYS / 2);
			stall_mode = $urandom_range(0, 3);
			random_keys(PHASE_KEYS / 2);
		end

		wait (pending == 0);
		repeat (50) @(posedge clk);
		$display("sent %0d keys over %0d load settings", keys_sent, settings_done);
		$display("results: %0d new, %0d duplicate, %0d full", new_seen, dup_seen, full_seen);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

/* sim.f */
design/lhd_pkg.sv
design/lhd_ram.sv
design/lhd_ctrl.sv
design/linear_hash_dedup_set.sv
design/lhd_checker.sv
dv/lhd_checker.sv
dv/linear_hash_dedup_set_tb.sv
